### design/fanlvl_pkg.sv
// ----------------------------------------------------------------------------
// fanlvl_pkg
// Shared constants for the fan level selector: table sizes, item kinds and
// stream word layout.
// ----------------------------------------------------------------------------
package fanlvl_pkg;

   localparam int LEVELS_DEF  = 8;
   localparam int SENSORS_DEF = 4;
   localparam int FANS_DEF    = 2;

   localparam int KIND_W      = 2;
   localparam int TEMP_W      = 9;
   localparam int POINT_W     = 8;
   localparam int RPM_W       = 16;
   localparam int LEVEL_W     = 3;
   localparam int SEL_W       = 2;

   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 24;

   localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_THRESH = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RPM    = 2'd2;

endpackage

### design/fan_level_hysteresis_table_core.sv
// ----------------------------------------------------------------------------
// fan_level_hysteresis_table_core
// Thermal fan level selector with hysteresis over a loaded level table.
//
// The req stream carries three kinds of words, told apart by req_tuser:
// temperature samples, threshold writes (on and off point per level and
// sensor) and rpm writes (rpm per level and fan). Write words give no
// response. A sample from an active system with valid selectors walks the
// current level down over the off points or up over the on points of the
// sensor chosen by csr_wdata, and answers on the rsp stream with the
// level's rpm, the level and an apply flag.
// The walk compares one level per threshold ram read; req_tready stays low
// until the sample's response is loaded.
// The response sits in an output register; the next word is taken while it
// waits, and a following sample stalls only in its ST_RESP state until the
// receiver takes the earlier response.
// Reset clears the level, the sample history and the applied targets; the
// tables hold nothing until written and need no clearing pass.
// ----------------------------------------------------------------------------
module fan_level_hysteresis_table_core #(
   parameter int LEVELS  = fanlvl_pkg::LEVELS_DEF,
   parameter int SENSORS = fanlvl_pkg::SENSORS_DEF,
   parameter int FANS    = fanlvl_pkg::FANS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [fanlvl_pkg::SEL_W-1:0]      csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // system_active, temperature, fan_select, level_index, sensor_index,
   // on_point, off_point, rpm_value
   input  logic [fanlvl_pkg::REQ_DATA_W-1:0] req_tdata,
   // kind
   input  logic [fanlvl_pkg::KIND_W-1:0]     req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // rpm, level, apply, zero fill
   output logic [fanlvl_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import fanlvl_pkg::*;

   localparam int LW  = $clog2(LEVELS);
   localparam int SW  = (SENSORS > 1) ? $clog2(SENSORS) : 1;
   localparam int FW  = (FANS > 1) ? $clog2(FANS) : 1;
   localparam int TA  = $clog2(LEVELS * SENSORS);
   localparam int RA  = $clog2(LEVELS * FANS);
   localparam logic [LW-1:0] LVL_MAX = LW'(LEVELS - 1);
   localparam logic [LW-1:0] LVL_ONE = LW'(1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_LOOK = 2'd2;
   localparam logic [1:0] ST_RESP = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [SEL_W-1:0]        sensor_sel_ff, sensor_sel_in;
   logic [LW-1:0]           cur_level_ff, cur_level_in;
   logic [LW-1:0]           idx_ff, idx_in;
   logic                    up_ff, up_in;
   logic signed [TEMP_W-1:0] temp_ff, temp_in;
   logic                    fan_ff, fan_in;
   logic signed [TEMP_W-1:0] prev_temp_ff [SENSORS];
   logic signed [TEMP_W-1:0] prev_temp_in [SENSORS];
   logic [RPM_W-1:0]        applied_ff [FANS];
   logic [RPM_W-1:0]        applied_in [FANS];
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RPM_W-1:0]        rsp_rpm_ff, rsp_rpm_in;
   logic [LEVEL_W-1:0]      rsp_level_ff, rsp_level_in;
   logic                    rsp_apply_ff, rsp_apply_in;

   logic                    in_active;
   logic signed [TEMP_W-1:0] in_temp;
   logic                    in_fan;
   logic [2:0]              in_lvl;
   logic [1:0]              in_sen;
   logic [POINT_W-1:0]      in_on;
   logic [POINT_W-1:0]      in_off;
   logic [RPM_W-1:0]        in_rpm;

   logic                    req_fire;
   logic                    sel_ok;
   logic                    fan_ok;
   logic                    start;
   logic [SW-1:0]           sel_idx;
   logic [FW-1:0]           fan_idx;
   logic signed [TEMP_W-1:0] prev_sel;
   logic                    resp_load;

   logic                    thr_we;
   logic [TA-1:0]           thr_wr_addr;
   logic [TA-1:0]           thr_rd_addr;
   logic [2*POINT_W-1:0]    thr_rd;
   logic signed [POINT_W-1:0] on_pt;
   logic signed [POINT_W-1:0] off_pt;

   logic                    rpm_we;
   logic [RA-1:0]           rpm_wr_addr;
   logic [RA-1:0]           rpm_rd_addr;
   logic [RPM_W-1:0]        rpm_rd;

   // request word unpacking
   assign in_active = req_tdata[0];
   assign in_temp   = req_tdata[9:1];
   assign in_fan    = req_tdata[10];
   assign in_lvl    = req_tdata[13:11];
   assign in_sen    = req_tdata[15:14];
   assign in_on     = req_tdata[23:16];
   assign in_off    = req_tdata[31:24];
   assign in_rpm    = req_tdata[47:32];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   assign sel_ok   = int'(sensor_sel_ff) < SENSORS;
   assign fan_ok   = int'(in_fan) < FANS;
   assign sel_idx  = SW'(sensor_sel_ff);
   assign fan_idx  = FW'(fan_ff);
   assign prev_sel = prev_temp_ff[sel_idx];
   assign start    = req_fire && (req_tuser == KIND_SAMPLE) && in_active && sel_ok && fan_ok;

   assign thr_we      = req_fire && (req_tuser == KIND_THRESH) &&
                        (int'(in_lvl) < LEVELS) && (int'(in_sen) < SENSORS);
   assign thr_wr_addr = TA'(int'(in_lvl) * SENSORS + int'(in_sen));
   assign thr_rd_addr = TA'(int'(idx_in) * SENSORS + int'(sensor_sel_ff));
   assign on_pt       = thr_rd[POINT_W-1:0];
   assign off_pt      = thr_rd[2*POINT_W-1:POINT_W];

   assign rpm_we      = req_fire && (req_tuser == KIND_RPM) &&
                        (int'(in_lvl) < LEVELS) && (int'(in_fan) < FANS);
   assign rpm_wr_addr = RA'(int'(in_lvl) * FANS + int'(in_fan));
   assign rpm_rd_addr = RA'(int'(cur_level_ff) * FANS + int'(fan_ff));

   assign resp_load = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_tready);

   fanlvl_ram #(
      .WIDTH (2 * POINT_W),
      .DEPTH (LEVELS * SENSORS)
   ) u_thr_ram (
      .clock   (clock),
      .wr_en   (thr_we),
      .wr_addr (thr_wr_addr),
      .wr_data ({in_off, in_on}),
      .rd_addr (thr_rd_addr),
      .rd_data (thr_rd)
   );

   fanlvl_ram #(
      .WIDTH (RPM_W),
      .DEPTH (LEVELS * FANS)
   ) u_rpm_ram (
      .clock   (clock),
      .wr_en   (rpm_we),
      .wr_addr (rpm_wr_addr),
      .wr_data (in_rpm),
      .rd_addr (rpm_rd_addr),
      .rd_data (rpm_rd)
   );

   always_comb begin
      state_in      = state_ff;
      sensor_sel_in = csr_we ? csr_wdata : sensor_sel_ff;
      cur_level_in  = cur_level_ff;
      idx_in        = idx_ff;
      up_in         = up_ff;
      temp_in       = temp_ff;
      fan_in        = fan_ff;
      prev_temp_in  = prev_temp_ff;
      applied_in    = applied_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_rpm_in    = rsp_rpm_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_apply_in  = rsp_apply_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               temp_in               = in_temp;
               fan_in                = in_fan;
               idx_in                = cur_level_ff;
               up_in                 = in_temp > prev_sel;
               prev_temp_in[sel_idx] = in_temp;
               if ((in_temp > prev_sel) ||
                   ((in_temp < prev_sel) && (cur_level_ff != '0))) begin
                  state_in = ST_WALK;
               end else begin
                  state_in = ST_LOOK;
               end
            end
         end
         ST_WALK: begin
            if (up_ff) begin
               if (temp_ff >= on_pt) begin
                  cur_level_in = idx_ff;
                  if (idx_ff == LVL_MAX) begin
                     state_in = ST_LOOK;
                  end else begin
                     idx_in = idx_ff + LVL_ONE;
                  end
               end else begin
                  state_in = ST_LOOK;
               end
            end else begin
               if (temp_ff <= off_pt) begin
                  cur_level_in = idx_ff - LVL_ONE;
                  if (idx_ff == LVL_ONE) begin
                     state_in = ST_LOOK;
                  end else begin
                     idx_in = idx_ff - LVL_ONE;
                  end
               end else begin
                  state_in = ST_LOOK;
               end
            end
         end
         ST_LOOK: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (resp_load) begin
               rsp_valid_in        = 1'b1;
               rsp_rpm_in          = rpm_rd;
               rsp_level_in        = LEVEL_W'(cur_level_ff);
               rsp_apply_in        = rpm_rd != applied_ff[fan_idx];
               applied_in[fan_idx] = rpm_rd;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sensor_sel_ff <= '0;
         cur_level_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int s = 0; s < SENSORS; s++) begin
            prev_temp_ff[s] <= '0;
         end
         for (int f = 0; f < FANS; f++) begin
            applied_ff[f] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         sensor_sel_ff <= sensor_sel_in;
         cur_level_ff  <= cur_level_in;
         rsp_valid_ff  <= rsp_valid_in;
         prev_temp_ff  <= prev_temp_in;
         applied_ff    <= applied_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      up_ff        <= up_in;
      temp_ff      <= temp_in;
      fan_ff       <= fan_in;
      rsp_rpm_ff   <= rsp_rpm_in;
      rsp_level_ff <= rsp_level_in;
      rsp_apply_ff <= rsp_apply_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RPM_W - LEVEL_W - 1)'(0),
                        rsp_apply_ff, rsp_level_ff, rsp_rpm_ff};

   // level stays inside the table
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      int'(cur_level_ff) < LEVELS)
      else $error("current level beyond table");

   // write words never start a walk
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_tuser != KIND_SAMPLE) |=> state_ff == ST_IDLE)
      else $error("write word left idle");

   // an upward walk never lowers the level
   a_up_monotonic: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) && up_ff |=> cur_level_ff >= $past(cur_level_ff))
      else $error("upward walk lowered level");

   // a loaded response reports the settled level
   a_resp_level: assert property (@(posedge clock) disable iff (reset)
      resp_load |=> rsp_tvalid && (rsp_tdata[18:16] == LEVEL_W'(cur_level_ff)))
      else $error("response level mismatch");

endmodule

### design/fanlvl_ram.sv
// ----------------------------------------------------------------------------
// fanlvl_ram
// Generic single write port, single read port ram with registered read data.
// ----------------------------------------------------------------------------
module fanlvl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the fan level selector against its own level-walk predictor.
// Loads the whole level table, runs directed edge words and then random
// temperature ramps with table rewrites under every sensor select value.
// Both streams idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import fanlvl_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic               active;
      logic [TEMP_W-1:0]  temp;
      logic               fan;
      logic [LEVEL_W-1:0] lvl;
      logic [SEL_W-1:0]   sen;
      logic [POINT_W-1:0] on_pt;
      logic [POINT_W-1:0] off_pt;
      logic [RPM_W-1:0]   rpm;
   } fan_word_type;

   typedef struct packed {
      logic [RPM_W-1:0]   rpm;
      logic [LEVEL_W-1:0] level;
      logic               apply;
   } fan_speed_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [SEL_W-1:0]      csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [KIND_W-1:0]     req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // predictor state
   int               fan_level;
   int               last_temp [SENSORS_DEF];
   int               on_point_tab [LEVELS_DEF*SENSORS_DEF];
   int               off_point_tab [LEVELS_DEF*SENSORS_DEF];
   logic [RPM_W-1:0] rpm_lut [LEVELS_DEF*FANS_DEF];
   logic [RPM_W-1:0] applied_rpm [FANS_DEF];
   int               sensor_sel;

   fan_speed_type pending_speed [$];
   int            mismatch_count;
   int            cycle_count;
   int            send_run;
   int            take_run;

   fan_level_hysteresis_table_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic int draw_gap(inout int run);
      if (run > 0) begin
         run--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         run = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 13);
   endfunction

   function automatic logic [POINT_W-1:0] clamp_point(int v);
      int c;
      c = (v > 127) ? 127 : ((v < -128) ? -128 : v);
      return c[POINT_W-1:0];
   endfunction

   function automatic fan_word_type rand_word();
      fan_word_type w;
      int unsigned  r;
      r = $urandom;
      w.kind   = r[1:0];
      w.active = r[2];
      w.fan    = r[3];
      w.lvl    = r[6:4];
      w.sen    = r[8:7];
      w.temp   = r[17:9];
      r = $urandom;
      w.on_pt  = r[7:0];
      w.off_pt = r[15:8];
      w.rpm    = r[31:16];
      return w;
   endfunction

   // table update, level walk and apply decision for one accepted word
   function automatic void step_fan_level(fan_word_type w);
      int            t;
      int            s;
      fan_speed_type res;
      t = $signed(w.temp);
      s = sensor_sel;
      case (w.kind)
         KIND_THRESH: begin
            on_point_tab[w.lvl*SENSORS_DEF + w.sen]  = $signed(w.on_pt);
            off_point_tab[w.lvl*SENSORS_DEF + w.sen] = $signed(w.off_pt);
         end
         KIND_RPM: begin
            rpm_lut[w.lvl*FANS_DEF + w.fan] = w.rpm;
         end
         KIND_SAMPLE: begin
            if (w.active) begin
               if (t < last_temp[s]) begin
                  for (int i = fan_level; i > 0; i--) begin
                     if (t <= off_point_tab[i*SENSORS_DEF + s]) fan_level = i - 1;
                     else break;
                  end
               end else if (t > last_temp[s]) begin
                  for (int i = fan_level; i < LEVELS_DEF; i++) begin
                     if (t >= on_point_tab[i*SENSORS_DEF + s]) fan_level = i;
                     else break;
                  end
               end
               last_temp[s] = t;
               res.rpm   = rpm_lut[fan_level*FANS_DEF + w.fan];
               res.level = fan_level[LEVEL_W-1:0];
               res.apply = (res.rpm != applied_rpm[w.fan]);
               if (res.apply) applied_rpm[w.fan] = res.rpm;
               pending_speed.push_back(res);
            end
         end
         default: ;
      endcase
   endfunction

   task automatic send_word(fan_word_type w);
      int gap;
      gap = draw_gap(send_run);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= {w.rpm, w.off_pt, w.on_pt, w.sen, w.lvl, w.fan, w.temp, w.active};
      req_tuser  <= w.kind;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      step_fan_level(w);
   endtask

   task automatic send_sample(int t, logic fan, logic active);
      fan_word_type w;
      w = rand_word();
      w.kind   = KIND_SAMPLE;
      w.temp   = t[TEMP_W-1:0];
      w.fan    = fan;
      w.active = active;
      send_word(w);
   endtask

   task automatic send_thresh(int lvl, int sen, int on_v, int off_v);
      fan_word_type w;
      w = rand_word();
      w.kind   = KIND_THRESH;
      w.lvl    = lvl[LEVEL_W-1:0];
      w.sen    = sen[SEL_W-1:0];
      w.on_pt  = clamp_point(on_v);
      w.off_pt = clamp_point(off_v);
      send_word(w);
   endtask

   task automatic send_rpm(int lvl, int fan, logic [RPM_W-1:0] rpm);
      fan_word_type w;
      w = rand_word();
      w.kind = KIND_RPM;
      w.lvl  = lvl[LEVEL_W-1:0];
      w.fan  = fan[0];
      w.rpm  = rpm;
      send_word(w);
   endtask

   // sender holds off until every pending response is back and the core is quiet
   task automatic settle_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_speed.size() != 0) @(posedge clock);
      repeat (LEVELS_DEF + 8) @(posedge clock);
   endtask

   task automatic write_select(int sel);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= sel[SEL_W-1:0];
      @(negedge clock);
      csr_we    <= 1'b0;
      sensor_sel = sel;
   endtask

   task automatic load_tables();
      int on_v;
      for (int l = 0; l < LEVELS_DEF; l++) begin
         for (int s = 0; s < SENSORS_DEF; s++) begin
            on_v = l*22 - 40 + s*3;
            send_thresh(l, s, on_v, on_v - 6 - s);
         end
         for (int f = 0; f < FANS_DEF; f++)
            send_rpm(l, f, 16'(1000 + l*450 + f*7));
      end
   endtask

   task automatic test_extremes();
      send_sample(255, 1'b0, 1'b1);
      send_sample(255, 1'b1, 1'b1);
      send_sample(-128, 1'b0, 1'b1);
      send_sample(127, 1'b1, 1'b1);
      send_sample(128, 1'b0, 1'b1);
      send_sample(-1, 1'b1, 1'b1);
      send_sample(0, 1'b0, 1'b1);
      send_rpm(0, 0, 16'hffff);
      send_rpm(7, 1, 16'h0000);
      send_sample(255, 1'b1, 1'b1);
      send_sample(-128, 1'b0, 1'b1);
   endtask

   task automatic test_ignored_words();
      fan_word_type w;
      send_sample(200, 1'b0, 1'b0);
      w = rand_word();
      w.kind = KIND_UNUSED;
      send_word(w);
      send_sample(200, 1'b1, 1'b1);
   endtask

   // unused marker -1 is just an ordinary threshold value
   task automatic test_minus_one_points();
      send_thresh(1, 0, -1, -1);
      send_thresh(2, 0, 127, -128);
      send_sample(-128, 1'b0, 1'b1);
      send_sample(-3, 1'b1, 1'b1);
      send_sample(-2, 1'b0, 1'b1);
      send_sample(-1, 1'b1, 1'b1);
      send_sample(0, 1'b0, 1'b1);
      send_sample(-1, 1'b1, 1'b1);
      send_sample(127, 1'b0, 1'b1);
      send_sample(-128, 1'b1, 1'b1);
   endtask

   task automatic run_random_phase(int sel, int count);
      fan_word_type w;
      int           done;
      int           r;
      int           t;
      int           tgt;
      int           step;
      int           on_v;
      settle_idle();
      write_select(sel);
      done = 0;
      t    = last_temp[sel];
      tgt  = t;
      while (done < count) begin
         r = $urandom_range(0, 99);
         w = rand_word();
         w.kind   = KIND_SAMPLE;
         w.active = 1'b1;
         if (r < 70) begin
            if (t == tgt) begin
               if ($urandom_range(0, 9) == 0) tgt = $urandom_range(0, 383) - 128;
               else tgt = $urandom_range(0, 240) - 60;
            end
            step = $urandom_range(1, 20);
            if (tgt > t) t = (tgt - t > step) ? t + step : tgt;
            else if (tgt < t) t = (t - tgt > step) ? t - step : tgt;
            w.temp = t[TEMP_W-1:0];
            done++;
         end else if (r < 78) begin
            t = $urandom_range(0, 383) - 128;
            w.temp = t[TEMP_W-1:0];
            done++;
         end else if (r < 84) begin
            w.active = 1'b0;
         end else if (r < 87) begin
            w.kind = KIND_UNUSED;
         end else if (r < 95) begin
            w.kind = KIND_THRESH;
            if ($urandom_range(0, 9) < 7) begin
               on_v = w.lvl*22 - 40 + w.sen*3 + $urandom_range(0, 16) - 8;
               w.on_pt  = clamp_point(on_v);
               w.off_pt = clamp_point(on_v - $urandom_range(0, 20));
            end
            done++;
         end else begin
            w.kind = KIND_RPM;
            case ($urandom_range(0, 7))
               0: w.rpm = 16'h0000;
               1: w.rpm = 16'hffff;
               default: ;
            endcase
            done++;
         end
         send_word(w);
      end
   endtask

   task automatic report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch: %s", msg);
   endtask

   always @(posedge clock) begin
      fan_speed_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_speed.size() == 0) begin
            report_mismatch($sformatf("unexpected word rsp_tdata=%h", rsp_tdata));
         end else begin
            want = pending_speed.pop_front();
            if (rsp_tdata[15:0] !== want.rpm)
               report_mismatch($sformatf("rpm exp %0d got %0d", want.rpm, rsp_tdata[15:0]));
            if (rsp_tdata[18:16] !== want.level)
               report_mismatch($sformatf("level exp %0d got %0d", want.level,
                                         rsp_tdata[18:16]));
            if (rsp_tdata[19] !== want.apply)
               report_mismatch($sformatf("apply exp %0d got %0d", want.apply, rsp_tdata[19]));
         end
      end
   end

   // receiver side stalls
   initial begin
      int n;
      rsp_tready = 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         n = draw_gap(take_run);
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   initial begin
      int sel_plan [6];
      sel_plan = '{3, 0, 2, 1, 3, 0};
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = '0;
      mismatch_count = 0;
      cycle_count    = 0;
      send_run       = 0;
      take_run       = 0;
      fan_level      = 0;
      sensor_sel     = 0;
      foreach (last_temp[i]) last_temp[i] = 0;
      foreach (applied_rpm[i]) applied_rpm[i] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      load_tables();
      test_extremes();
      test_ignored_words();
      test_minus_one_points();
      foreach (sel_plan[i]) run_random_phase(sel_plan[i], 105);
      settle_idle();

      if (mismatch_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
